[design/usbwl_pkg.sv]
`default_nettype none

package usbwl_pkg;

	localparam int MAX_RULES_DEF = 16;
	localparam int ID_BITS_DEF   = 16;

	typedef enum logic [1:0] {
		OP_CHECK  = 2'd0,
		OP_ADD    = 2'd1,
		OP_DELETE = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_DENIED    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DONE
	} fsm_t;

	// one rule or one device, without its id
	typedef struct packed {
		logic [15:0] vendor;
		logic [15:0] product;
		logic [7:0]  serial;
		logic        product_wild;
		logic        serial_wild;
	} rule_t;

	// walk token passed from cell to cell
	typedef struct packed {
		logic valid;
		logic flag;
	} tok_t;

endpackage

`default_nettype wire

[design/usb_device_whitelist_table_top.sv]
// add and flush: result beat is offered the cycle after the input beat is accepted
// check and delete: a token walks the row of rule cells, one cell per cycle,
// and the result is offered once the token has left the last cell
// one item at a time: the next input beat can be taken the cycle after the result beat
// arst_n clears the table to empty (rule count 0) and the id counter to 1
`default_nettype none

module usb_device_whitelist_table_top
	import usbwl_pkg::*;
#(
	parameter int MAX_RULES = MAX_RULES_DEF,
	parameter int ID_BITS   = ID_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  func,
	input  wire  [15:0] vendor_id,
	input  wire  [15:0] product_id,
	input  wire  [7:0]  serial_index,
	input  wire         product_wild,
	input  wire         serial_wild,
	input  wire  [15:0] rule_id,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  status,
	output logic [15:0] assigned_id,
	output logic [4:0]  rule_count
);

	localparam int CW = $clog2(MAX_RULES + 1);

	// control state
	fsm_t               state_q;
	fsm_t               state_nxt;
	logic [CW-1:0]      count_q;
	logic [ID_BITS-1:0] id_ctr_q;
	logic               start_q;

	// query held for the walk
	op_t                op_q;
	rule_t              query_q;
	logic [ID_BITS-1:0] want_q;

	// result register
	status_t            status_q;
	logic [15:0]        assigned_q;

	// row of cells
	tok_t               tok_arr [MAX_RULES];
	rule_t              rule_arr [MAX_RULES];
	logic [ID_BITS-1:0] id_arr [MAX_RULES];
	logic [MAX_RULES-1:0] tok_valid;
	tok_t               tok_first;

	logic               in_beat;
	logic               out_beat;
	logic               walk_done;
	op_t                op_in;
	rule_t              wr_rule;
	logic               add_ok;
	logic [31:0]        rid_ext;
	logic [31:0]        idc_ext;
	logic [7:0]         cnt_ext;

	assign op_in     = op_t'(func);
	assign in_beat   = in_valid && in_ready;
	assign out_beat  = out_valid && out_ready;
	assign walk_done = tok_arr[MAX_RULES-1].valid;
	assign add_ok    = count_q < CW'(MAX_RULES);

	// wider or narrower id fields are zero-extended or cut to size
	assign rid_ext = 32'(rule_id);
	assign idc_ext = 32'(id_ctr_q);
	assign cnt_ext = 8'(count_q);

	assign wr_rule.vendor       = vendor_id;
	assign wr_rule.product      = product_id;
	assign wr_rule.serial       = serial_index;
	assign wr_rule.product_wild = product_wild;
	assign wr_rule.serial_wild  = serial_wild;

	assign tok_first.valid = start_q;
	assign tok_first.flag  = 1'b0;

	// cell k holds slot k; slots below the count are live, packed from slot 0
	for (genvar k = 0; k < MAX_RULES; k++) begin : g_cell
		tok_t               tin;
		rule_t              nrule;
		logic [ID_BITS-1:0] nid;
		logic               wr_k;

		if (k == 0) begin : g_head
			assign tin = tok_first;
		end else begin : g_body
			assign tin = tok_arr[k-1];
		end

		if (k == MAX_RULES - 1) begin : g_tail
			assign nrule = rule_arr[k];
			assign nid   = id_arr[k];
		end else begin : g_mid
			assign nrule = rule_arr[k+1];
			assign nid   = id_arr[k+1];
		end

		// an add lands in the first free slot at once
		assign wr_k = in_beat && (op_in == OP_ADD) && (count_q == CW'(k));

		assign tok_valid[k] = tok_arr[k].valid;

		usbwl_cell #(
			.ID_BITS (ID_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_in    (tin),
			.tok_out   (tok_arr[k]),
			.op        (op_q),
			.occupied  (CW'(k) < count_q),
			.wr_en     (wr_k),
			.wr_rule   (wr_rule),
			.wr_id     (id_ctr_q),
			.query     (query_q),
			.want      (want_q),
			.next_rule (nrule),
			.next_id   (nid),
			.rule      (rule_arr[k]),
			.id        (id_arr[k])
		);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op_in == OP_CHECK || op_in == OP_DELETE) begin
						state_nxt = S_WALK;
					end else begin
						state_nxt = S_DONE;
					end
				end
			end
			S_WALK: begin
				if (walk_done) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (out_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE:  in_ready  = 1'b1;
			S_DONE:  out_valid = 1'b1;
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			id_ctr_q <= ID_BITS'(1);
			start_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			start_q <= in_beat && (op_in == OP_CHECK || op_in == OP_DELETE);
			if (in_beat) begin
				case (op_in)
					OP_ADD: begin
						if (add_ok) begin
							count_q  <= count_q + CW'(1);
							id_ctr_q <= id_ctr_q + ID_BITS'(1);
						end
					end
					OP_FLUSH: begin
						count_q  <= '0;
						id_ctr_q <= ID_BITS'(1);
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end else if (walk_done && (op_q == OP_DELETE) && tok_arr[MAX_RULES-1].flag) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// query capture and result register
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q       <= op_in;
			query_q    <= wr_rule;
			want_q     <= rid_ext[ID_BITS-1:0];
			status_q   <= ST_OK;
			assigned_q <= '0;
			if (op_in == OP_ADD) begin
				if (add_ok) begin
					assigned_q <= idc_ext[15:0];
				end else begin
					status_q <= ST_FULL;
				end
			end
		end else if (walk_done) begin
			if (op_q == OP_DELETE) begin
				status_q <= tok_arr[MAX_RULES-1].flag ? ST_OK : ST_NOT_FOUND;
			end else begin
				// an empty table admits everything
				status_q <= (count_q != '0 && !tok_arr[MAX_RULES-1].flag) ? ST_DENIED : ST_OK;
			end
		end
	end

	assign status      = status_q;
	assign assigned_id = assigned_q;
	assign rule_count  = cnt_ext[4:0];

	// only one walk token in the row at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_valid, start_q}))
		else $error("more than one walk token in the cell row");

	// a walk only runs in the walk state
	a_walk_state: assert property (@(posedge clk) disable iff (!arst_n)
		(start_q || walk_done) |-> (state_q == S_WALK))
		else $error("walk token outside walk state");

	// count never exceeds the table size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RULES))
		else $error("rule count above table size");

	// result beat offered only after the walk or an immediate op, never with a new beat
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |=> !out_valid && in_ready)
		else $error("result still offered after it was taken");

endmodule

`default_nettype wire

[design/usbwl_cell.sv]
`default_nettype none

module usbwl_cell
	import usbwl_pkg::*;
#(
	parameter int ID_BITS = ID_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tok_t                tok_in,
	output tok_t                tok_out,
	input  op_t                 op,
	input  wire                 occupied,
	input  wire                 wr_en,
	input  rule_t               wr_rule,
	input  wire [ID_BITS-1:0]   wr_id,
	input  rule_t               query,
	input  wire [ID_BITS-1:0]   want,
	input  rule_t               next_rule,
	input  wire [ID_BITS-1:0]   next_id,
	output rule_t               rule,
	output logic [ID_BITS-1:0]  id
);

	rule_t              rule_q;
	logic [ID_BITS-1:0] id_q;
	tok_t               tok_q;
	logic               hit_chk;
	logic               hit_del;
	logic               shift;
	logic               flag_nxt;

	assign hit_chk = occupied && (rule_q.vendor == query.vendor)
		&& (rule_q.product_wild || (rule_q.product == query.product))
		&& (rule_q.serial_wild || (rule_q.serial == query.serial));
	assign hit_del = occupied && !tok_in.flag && (id_q == want);

	always_comb begin
		flag_nxt = tok_in.flag;
		shift    = 1'b0;
		case (op)
			OP_CHECK: begin
				flag_nxt = tok_in.flag | hit_chk;
			end
			OP_DELETE: begin
				flag_nxt = tok_in.flag | hit_del;
				// close the gap: this cell and every later one take the next rule
				shift    = tok_in.valid && (tok_in.flag || hit_del);
			end
			default: begin
				flag_nxt = tok_in.flag;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.flag  <= tok_in.valid & flag_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rule_q <= wr_rule;
			id_q   <= wr_id;
		end else if (shift) begin
			rule_q <= next_rule;
			id_q   <= next_id;
		end
	end

	assign tok_out = tok_q;
	assign rule    = rule_q;
	assign id      = id_q;

endmodule

`default_nettype wire
